### rtl/cirm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and sizes for the interval run merger.
// Used by cirm_front, cirm_back and the top level.
package cirm_pkg;

    localparam int SeqW = 16;
    localparam int PosW = 32;
    localparam int SigW = 32;
    localparam int CntW = 32;

    localparam int MidDepthDefault = 4;
    localparam int OutDepthDefault = 4;

    // Row after classification in the front end.
    typedef struct packed {
        logic [SeqW-1:0]        seq;
        logic [PosW-1:0]        start_pos;
        logic [PosW-1:0]        end_pos;
        logic signed [SigW-1:0] sig;
        logic                   final_row;
        logic                   qual;
        logic [CntW-1:0]        idx;
    } t_row;

    // One output record.
    typedef struct packed {
        logic [SeqW-1:0]        seq;
        logic [PosW-1:0]        first_start;
        logic [PosW-1:0]        last_end;
        logic signed [SigW-1:0] min_sig;
        logic [CntW-1:0]        rows;
        logic [CntW-1:0]        first_idx;
        logic [CntW-1:0]        last_idx;
        logic                   none_found;
        logic                   last_rec;
    } t_rec;

    localparam int RowW = $bits(t_row);
    localparam int RecW = $bits(t_rec);

endpackage : cirm_pkg
`default_nettype wire

### rtl/cirm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Small register queue, one push and one pop per cycle, head read directly.
// No dependencies.
module cirm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == FullCnt);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + AW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + AW'(1);
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule : cirm_fifo
`default_nettype wire

### rtl/cirm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: holds the threshold, numbers rows and classifies each one.
// Depends on cirm_pkg.
module cirm_front import cirm_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic signed [SigW-1:0] i_cfg_min_signal,
    input  wire logic                   i_push,
    input  wire logic [SeqW-1:0]        i_seq_id,
    input  wire logic [PosW-1:0]        i_start_pos,
    input  wire logic [PosW-1:0]        i_end_pos,
    input  wire logic signed [SigW-1:0] i_signal,
    input  wire logic                   i_final_row,
    input  wire logic                   i_q_full,
    output logic                        o_q_push,
    output t_row                        o_q_row
);
    logic signed [SigW-1:0] r_min_signal;
    logic [CntW-1:0]        r_row_cnt;

    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_q_row.seq       = i_seq_id;
        o_q_row.start_pos = i_start_pos;
        o_q_row.end_pos   = i_end_pos;
        o_q_row.sig       = i_signal;
        o_q_row.final_row = i_final_row;
        o_q_row.qual      = (i_signal >= r_min_signal);
        o_q_row.idx       = r_row_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_signal <= '0;
            r_row_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_signal <= i_cfg_min_signal;
            end
            if (o_q_push) begin
                // position restarts after the final row of a stream
                r_row_cnt <= i_final_row ? '0 : r_row_cnt + CntW'(1);
            end
        end
    end

endmodule : cirm_front
`default_nettype wire

### rtl/cirm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: keeps the open run, merges rows into it and emits closed runs.
// Depends on cirm_pkg.
module cirm_back import cirm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_row_valid,
    input  wire t_row i_row,
    output logic      o_row_pop,
    input  wire logic i_rec_full,
    output logic      o_rec_push,
    output t_rec      o_rec
);
    logic                   r_open;
    logic [SeqW-1:0]        r_seq;
    logic [PosW-1:0]        r_start;
    logic [PosW-1:0]        r_end;
    logic signed [SigW-1:0] r_min;
    logic [CntW-1:0]        r_cnt;
    logic [CntW-1:0]        r_first;
    logic [CntW-1:0]        r_last;
    // set when a final row has closed a run and still owes its flush record
    logic                   r_half;

    logic                   n_open;
    logic [SeqW-1:0]        n_seq;
    logic [PosW-1:0]        n_start;
    logic [PosW-1:0]        n_end;
    logic signed [SigW-1:0] n_min;
    logic [CntW-1:0]        n_cnt;
    logic [CntW-1:0]        n_first;
    logic [CntW-1:0]        n_last;

    logic go;
    logic qual;
    logic extend;
    logic close;

    assign go     = i_row_valid && !i_rec_full;
    assign qual   = i_row.qual && !r_half;
    assign extend = qual && r_open && (i_row.seq == r_seq) && (i_row.start_pos == r_end);
    assign close  = qual && r_open && !extend;

    always_comb begin
        n_open  = r_open;
        n_seq   = r_seq;
        n_start = r_start;
        n_end   = r_end;
        n_min   = r_min;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_last  = r_last;
        if (extend) begin
            n_cnt  = (r_cnt == '1) ? r_cnt : r_cnt + CntW'(1);
            n_end  = i_row.end_pos;
            n_last = i_row.idx;
            if (i_row.sig < r_min) begin
                n_min = i_row.sig;
            end
        end else if (qual) begin
            n_open  = 1'b1;
            n_seq   = i_row.seq;
            n_start = i_row.start_pos;
            n_end   = i_row.end_pos;
            n_min   = i_row.sig;
            n_cnt   = CntW'(1);
            n_first = i_row.idx;
            n_last  = i_row.idx;
        end
    end

    always_comb begin
        o_rec_push = go && (close || i_row.final_row);
        // a close with a final row pops only on its second pass
        o_row_pop  = go && !(close && i_row.final_row);
        if (close) begin
            o_rec.seq         = r_seq;
            o_rec.first_start = r_start;
            o_rec.last_end    = r_end;
            o_rec.min_sig     = r_min;
            o_rec.rows        = r_cnt;
            o_rec.first_idx   = r_first;
            o_rec.last_idx    = r_last;
            o_rec.none_found  = 1'b0;
            o_rec.last_rec    = 1'b0;
        end else if (n_open) begin
            o_rec.seq         = n_seq;
            o_rec.first_start = n_start;
            o_rec.last_end    = n_end;
            o_rec.min_sig     = n_min;
            o_rec.rows        = n_cnt;
            o_rec.first_idx   = n_first;
            o_rec.last_idx    = n_last;
            o_rec.none_found  = 1'b0;
            o_rec.last_rec    = 1'b1;
        end else begin
            o_rec            = '0;
            o_rec.none_found = 1'b1;
            o_rec.last_rec   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_seq   <= '0;
            r_start <= '0;
            r_end   <= '0;
            r_min   <= '0;
            r_cnt   <= '0;
            r_first <= '0;
            r_last  <= '0;
            r_half  <= 1'b0;
        end else if (go) begin
            if (i_row.final_row && !close) begin
                r_open  <= 1'b0;
                r_seq   <= '0;
                r_start <= '0;
                r_end   <= '0;
                r_min   <= '0;
                r_cnt   <= '0;
                r_first <= '0;
                r_last  <= '0;
                r_half  <= 1'b0;
            end else begin
                r_open  <= n_open;
                r_seq   <= n_seq;
                r_start <= n_start;
                r_end   <= n_end;
                r_min   <= n_min;
                r_cnt   <= n_cnt;
                r_first <= n_first;
                r_last  <= n_last;
                r_half  <= close && i_row.final_row;
            end
        end
    end

endmodule : cirm_back
`default_nettype wire

### rtl/contiguous_interval_run_merger_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Interval run merger. Rows enter through a queue-style push/full port and
// merged runs leave through an empty/pop port. One row is taken per clock
// while the row queue is not full. The back end emits at most one record per
// clock while the result queue has room, so a final row that both closes a run
// and flushes the new one holds the back end for a second pass. A row queue
// between front and back and a result queue at the output let each side
// stall on its own. Write the threshold only while idle.
module contiguous_interval_run_merger_unit import cirm_pkg::*; #(
    parameter int MID_DEPTH = MidDepthDefault,
    parameter int OUT_DEPTH = OutDepthDefault
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic signed [SigW-1:0] i_cfg_min_signal,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [SeqW-1:0]        i_seq_id,
    input  wire logic [PosW-1:0]        i_start_pos,
    input  wire logic [PosW-1:0]        i_end_pos,
    input  wire logic signed [SigW-1:0] i_signal,
    input  wire logic                   i_final_row,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [SeqW-1:0]             o_run_seq,
    output logic [PosW-1:0]             o_run_first_start,
    output logic [PosW-1:0]             o_run_last_end,
    output logic signed [SigW-1:0]      o_run_min_signal,
    output logic [CntW-1:0]             o_run_rows,
    output logic [CntW-1:0]             o_first_index,
    output logic [CntW-1:0]             o_last_index,
    output logic                        o_none_found,
    output logic                        o_last_record
);
    logic q_push;
    t_row q_in;
    t_row q_out;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic rec_push;
    logic rec_full;
    t_rec rec_in;
    t_rec rec_out;

    assign full = q_full;

    cirm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_min_signal (i_cfg_min_signal),
        .i_push           (push),
        .i_seq_id         (i_seq_id),
        .i_start_pos      (i_start_pos),
        .i_end_pos        (i_end_pos),
        .i_signal         (i_signal),
        .i_final_row      (i_final_row),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_row          (q_in)
    );

    cirm_fifo #(
        .WIDTH (RowW),
        .DEPTH (MID_DEPTH)
    ) u_row_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    cirm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_valid (!q_empty),
        .i_row       (q_out),
        .o_row_pop   (q_pop),
        .i_rec_full  (rec_full),
        .o_rec_push  (rec_push),
        .o_rec       (rec_in)
    );

    cirm_fifo #(
        .WIDTH (RecW),
        .DEPTH (OUT_DEPTH)
    ) u_rec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (rec_in),
        .o_full  (rec_full),
        .i_pop   (pop),
        .o_data  (rec_out),
        .o_empty (empty)
    );

    assign o_run_seq         = rec_out.seq;
    assign o_run_first_start = rec_out.first_start;
    assign o_run_last_end    = rec_out.last_end;
    assign o_run_min_signal  = rec_out.min_sig;
    assign o_run_rows        = rec_out.rows;
    assign o_first_index     = rec_out.first_idx;
    assign o_last_index      = rec_out.last_idx;
    assign o_none_found      = rec_out.none_found;
    assign o_last_record     = rec_out.last_rec;

endmodule : contiguous_interval_run_merger_unit
`default_nettype wire
